// ===== rtl/fqrv_pkg.sv =====
// shared types, codes and defaults for the queue with remove by value
`default_nettype none

package fqrv_pkg;

	// default number of entries
	localparam int DEPTH_DEF = 16;

	// operation codes carried in the request
	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	// one request
	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] value;
	} req_t;

	// one result
	typedef struct packed {
		logic signed [31:0] popped_value;
		status_t            status;
		logic [4:0]         fill_level;
	} rsp_t;

	// controls broadcast to every cell
	typedef struct packed {
		logic               load;   // register match flags against key
		logic [31:0]        key;
		logic               push;   // write data into first free cell
		logic               pop;    // every cell takes its tail neighbor
		logic               rem;    // cells at or after the match take their neighbor
		logic signed [31:0] data;
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/fqrv_cell.sv =====
// one queue cell: an entry, its occupied flag and its match flag
`default_nettype none

module fqrv_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fqrv_pkg::ctl_t     ctl,
	input  wire logic               prev_occ,
	input  wire logic               hit_in,
	input  wire logic signed [31:0] next_value,
	input  wire logic               next_occ,
	output logic signed [31:0]      value,
	output logic                    occ,
	output logic                    hit_out
);

	logic signed [31:0] value_q;
	logic               occ_q;
	logic               match_q;
	logic               take_next;
	logic               take_push;

	// a match here or anywhere toward the head moves this cell
	assign hit_out   = hit_in | match_q;
	assign take_next = ctl.pop | (ctl.rem & hit_out);
	assign take_push = ctl.push & ~occ_q & prev_occ;

	// occupancy and match flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.load)
				match_q <= occ_q & (value_q == $signed(ctl.key));
			if (take_next)
				occ_q <= next_occ;
			else if (take_push)
				occ_q <= 1'b1;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (take_next)
			value_q <= next_value;
		else if (take_push)
			value_q <= ctl.data;
	end

	assign value = value_q;
	assign occ   = occ_q;

endmodule

`default_nettype wire

// ===== rtl/fifo_queue_with_remove_by_value_top.sv =====
// top level: bounded queue of signed words with push, pop and remove by value
`default_nettype none

// Bounded FIFO of DEPTH signed 32-bit entries built as a row of cells, the head
// in cell 0. A request runs in steps: in the first every cell compares the
// search value with its entry and registers a match flag; in the second a match
// flag ripples toward the tail and the cells shift, load or hold at once. A new
// request is accepted when that second step is free and the result register is
// empty or being read, so no request is taken while the last one is in its second
// step, whatever DEPTH. A push into a full queue is dropped (status full), a pop
// of an empty queue returns -1 (status empty), and a remove with no match changes
// nothing (status no match). Every result reports the fill level after the
// request. Entries need no clearing after reset; only occupied cells are read.
module fifo_queue_with_remove_by_value_top #(
	parameter int DEPTH = fqrv_pkg::DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire fqrv_pkg::req_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output fqrv_pkg::rsp_t      out_data
);

	localparam int CW = $clog2(DEPTH + 1);

	logic               accept;
	logic               valid_s1;
	logic [1:0]         func_s1;
	logic signed [31:0] value_s1;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_next;
	logic               out_valid_q;
	fqrv_pkg::rsp_t     out_q;
	fqrv_pkg::rsp_t     rsp;
	fqrv_pkg::ctl_t     ctl;
	logic               full;
	logic               empty;
	logic               found;

	logic signed [31:0] value_w [0:DEPTH];
	logic [DEPTH:0]     occ_w;
	logic [DEPTH:0]     hit_w;
	logic [DEPTH-1:0]   prev_w;

	// handshake
	assign in_ready = ~valid_s1 & (~out_valid_q | out_ready);
	assign accept   = in_valid & in_ready;

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= in_data.func;
			value_s1 <= in_data.value;
		end
	end

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign found = hit_w[DEPTH];

	// cell controls
	always_comb begin
		ctl.load = accept;
		ctl.key  = in_data.value;
		ctl.data = value_s1;
		ctl.push = valid_s1 & (func_s1 == fqrv_pkg::OP_PUSH) & ~full;
		ctl.pop  = valid_s1 & (func_s1 == fqrv_pkg::OP_POP) & ~empty;
		ctl.rem  = valid_s1 & (func_s1 == fqrv_pkg::OP_REMOVE);
	end

	// chain ends
	assign value_w[DEPTH] = '0;
	assign occ_w[DEPTH]   = 1'b0;
	assign hit_w[0]       = 1'b0;

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_w[i] = 1'b1;
		end else begin : g_body
			assign prev_w[i] = occ_w[i-1];
		end

		fqrv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_occ   (prev_w[i]),
			.hit_in     (hit_w[i]),
			.next_value (value_w[i+1]),
			.next_occ   (occ_w[i+1]),
			.value      (value_w[i]),
			.occ        (occ_w[i]),
			.hit_out    (hit_w[i+1])
		);
	end

	// result and new fill count
	always_comb begin
		rsp.popped_value = '0;
		rsp.status       = fqrv_pkg::ST_OK;
		count_next       = count_q;
		case (func_s1)
			fqrv_pkg::OP_PUSH: begin
				if (full)
					rsp.status = fqrv_pkg::ST_FULL;
				else
					count_next = count_q + CW'(1);
			end
			fqrv_pkg::OP_POP: begin
				if (empty) begin
					rsp.status       = fqrv_pkg::ST_EMPTY;
					rsp.popped_value = -32'sd1;
				end else begin
					rsp.popped_value = value_w[0];
					count_next       = count_q - CW'(1);
				end
			end
			fqrv_pkg::OP_REMOVE: begin
				if (found)
					count_next = count_q - CW'(1);
				else
					rsp.status = fqrv_pkg::ST_NOMATCH;
			end
			default: begin
				rsp.status = fqrv_pkg::ST_OK;
			end
		endcase
		rsp.fill_level = 5'(count_next);
	end

	// fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s1) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			out_q <= rsp;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_w) == int'(count_q))
		else $error("occupied cells disagree with fill count");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> out_valid_q && !valid_s1)
		else $error("executed request gave no result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !out_valid_q || $past(out_ready))
		else $error("result register overrun");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the queue with remove by value: each result checked against a local queue model
`default_nettype none

module tb;
	import fqrv_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [1:0] OP_NONE = 2'd3;   // selector with no meaning
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;

	// local copy of the queue contents, head first, and results still owed
	logic signed [31:0] held_entries[$];
	rsp_t pending_rsp[$];
	int error_count = 0;
	int cycle_count = 0;
	int burst_left = 0;

	fifo_queue_with_remove_by_value_top #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// apply one request to the local queue and return the result it should give
	function automatic rsp_t queue_apply(req_t r);
		rsp_t o;
		int idx;
		o.popped_value = '0;
		o.status = ST_OK;
		idx = -1;
		case (r.func)
			OP_PUSH: begin
				if (held_entries.size() >= DEPTH)
					o.status = ST_FULL;
				else
					held_entries.push_back(r.value);
			end
			OP_POP: begin
				if (held_entries.size() == 0) begin
					o.status = ST_EMPTY;
					o.popped_value = -32'sd1;
				end else begin
					o.popped_value = held_entries.pop_front();
				end
			end
			OP_REMOVE: begin
				foreach (held_entries[i])
					if (idx < 0 && held_entries[i] == r.value)
						idx = i;
				if (idx < 0)
					o.status = ST_NOMATCH;
				else
					held_entries.delete(idx);
			end
			default: ;
		endcase
		o.fill_level = 5'(held_entries.size());
		return o;
	endfunction

	// value source: often entries already held, else small values, extremes or any word
	function automatic logic signed [31:0] pick_value(bit from_held);
		int sel;
		sel = $urandom_range(0, 9);
		if (from_held && held_entries.size() > 0 && sel < 5)
			return held_entries[$urandom_range(0, held_entries.size() - 1)];
		if (sel < 7)
			return int'($urandom_range(0, 8)) - 4;
		if (sel == 7) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return -32'sd1;
				default: return 32'sd0;
			endcase
		end
		return $urandom;
	endfunction

	// send one request, with bursts and random gaps on the sending side
	task automatic send_req(input logic [1:0] func, input logic signed [31:0] value);
		req_t r;
		int gap;
		bit taken;
		r.func = func;
		r.value = value;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				in_data <= req_t'({2'($urandom_range(0, 3)), 32'($urandom)});
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= r;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			if (taken)
				pending_rsp.push_back(queue_apply(r));
			@(posedge clk);
		end
	endtask

	// result receiver stall pattern, switching between randomly chosen modes
	initial begin : receiver
		int mode;
		int hold;
		mode = 0;
		hold = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (cycle_count % 64 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (cycle_count % 4 == 0);
				default: begin
					if (hold > 0) begin
						hold--;
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
						if ($urandom_range(0, 3) == 0)
							hold = $urandom_range(1, 8);
					end
				end
			endcase
		end
	end

	// result checker, sampled mid-cycle when outputs are settled
	always @(negedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				error_count++;
				$display("%0t: result with no request outstanding, expected none, %s %0d %0d %0d",
					$time, "actual", out_data.popped_value, out_data.status,
					out_data.fill_level);
			end else begin
				want = pending_rsp.pop_front();
				if (out_data.popped_value !== want.popped_value) begin
					error_count++;
					$display("%0t: popped_value mismatch, expected %0d, actual %0d",
						$time, want.popped_value, out_data.popped_value);
				end
				if (out_data.status !== want.status) begin
					error_count++;
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, out_data.status);
				end
				if (out_data.fill_level !== want.fill_level) begin
					error_count++;
					$display("%0t: fill_level mismatch, expected %0d, actual %0d",
						$time, want.fill_level, out_data.fill_level);
				end
			end
		end
	end

	// pop, remove and no-op selector on an empty queue
	task automatic test_empty_queue();
		send_req(OP_POP, $urandom);
		send_req(OP_REMOVE, 32'sd0);
		send_req(OP_NONE, $urandom);
		send_req(OP_REMOVE, -32'sd1);
	endtask

	// extreme values through push, remove and pop
	task automatic test_extremes();
		send_req(OP_PUSH, 32'sh7fffffff);
		send_req(OP_PUSH, 32'sh80000000);
		send_req(OP_PUSH, -32'sd1);
		send_req(OP_PUSH, 32'sd0);
		send_req(OP_PUSH, 32'sd1);
		send_req(OP_NONE, 32'sh80000000);
		send_req(OP_REMOVE, 32'sh80000000);
		send_req(OP_REMOVE, 32'sh7fffffff);
		send_req(OP_POP, 32'sd0);
		send_req(OP_POP, 32'sd0);
		send_req(OP_POP, 32'sd0);
		send_req(OP_POP, 32'sd0);
	endtask

	// remove takes the earliest match and closes the gap
	task automatic test_remove_order();
		send_req(OP_PUSH, 32'sd5);
		send_req(OP_PUSH, 32'sd9);
		send_req(OP_PUSH, 32'sd5);
		send_req(OP_REMOVE, 32'sd5);
		send_req(OP_REMOVE, 32'sd9);
		send_req(OP_REMOVE, 32'sd9);
		send_req(OP_POP, 32'sd0);
	endtask

	// fill past capacity, remove the values of the tail, head and middle entries, then drain past empty
	task automatic test_full_queue();
		repeat (DEPTH + 3)
			send_req(OP_PUSH, pick_value(1'b1));
		send_req(OP_REMOVE, held_entries[DEPTH - 1]);
		send_req(OP_PUSH, $urandom);
		send_req(OP_PUSH, $urandom);
		send_req(OP_REMOVE, held_entries[0]);
		send_req(OP_REMOVE, held_entries[DEPTH / 2]);
		repeat (DEPTH)
			send_req(OP_POP, $urandom);
	endtask

	// random traffic in phases weighted toward push, pop, remove or a mix
	task automatic test_random_traffic(input int phases, input int per_phase);
		int wpush;
		int wpop;
		int wrem;
		int pick;
		for (int p = 0; p < phases; p++) begin
			case (p % 4)
				0: begin wpush = 6; wpop = 1; wrem = 2; end
				1: begin wpush = 2; wpop = 2; wrem = 5; end
				2: begin wpush = 1; wpop = 5; wrem = 2; end
				default: begin wpush = 3; wpop = 3; wrem = 3; end
			endcase
			repeat (per_phase) begin
				pick = $urandom_range(0, wpush + wpop + wrem - 1);
				if ($urandom_range(0, 31) == 0)
					send_req(OP_NONE, $urandom);
				else if (pick < wpush)
					send_req(OP_PUSH, pick_value(1'b1));
				else if (pick < wpush + wpop)
					send_req(OP_POP, $urandom);
				else
					send_req(OP_REMOVE, pick_value(1'b1));
			end
		end
	endtask

	// main sequence
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_extremes();
		test_remove_order();
		test_full_queue();
		test_random_traffic(8, 42);

		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
